FILE: hw/rtl/hsb_pkg.sv
// Package for the semaphore bank: payload structs, error and op codes,
// enable patterns, queue sizing and the back-end state type.
// No dependencies.
package hsb_pkg;

  localparam int MEM_WORDS   = 64;
  localparam int ADDR_W      = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int IDX_W       = 8;
  localparam int BE_W        = 8;
  localparam int DATA_W      = 64;
  localparam int LANE_W      = 32;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [BE_W-1:0] BE_HALF_0 = 8'h03;
  localparam logic [BE_W-1:0] BE_HALF_1 = 8'h0C;
  localparam logic [BE_W-1:0] BE_HALF_2 = 8'h30;
  localparam logic [BE_W-1:0] BE_HALF_3 = 8'hC0;
  localparam logic [BE_W-1:0] BE_WORD_LO = 8'h0F;
  localparam logic [BE_W-1:0] BE_WORD_HI = 8'hF0;

  localparam logic [LANE_W-1:0] SEM_FREE   = 32'd0;
  localparam logic [LANE_W-1:0] SEM_TAKEN  = 32'd1;
  localparam logic [LANE_W-1:0] SEM_LOCKED = 32'd2;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ERR_OK          = 2'd0,
    ERR_RANGE       = 2'd1,
    ERR_ENABLE      = 2'd2,
    ERR_DOUBLE_LOCK = 2'd3
  } err_code_t;

  typedef struct packed {
    op_t               op;
    logic [IDX_W-1:0]  word_index;
    logic [BE_W-1:0]   byte_enable;
    logic [DATA_W-1:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    err_code_t         error_code;
  } out_item_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] addr;
    err_code_t         err;
    logic              is_word;
    logic              word_hi;
    logic [BE_W-1:0]   byte_enable;
    logic [DATA_W-1:0] write_data;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_EXEC
  } back_state_t;

endpackage

FILE: hw/rtl/hsb_front.sv
// Front end: checks the address and decodes the byte enable of an access.
// Depends on hsb_pkg.
module hsb_front (
  input  hsb_pkg::in_item_t item,
  output hsb_pkg::cmd_t     cmd
);
  import hsb_pkg::*;

  logic legal;
  logic is_word;

  always_comb begin
    legal   = 1'b1;
    is_word = 1'b0;
    unique case (item.byte_enable) inside
      8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80: begin
        legal = 1'b1;
      end
      BE_HALF_0, BE_HALF_1, BE_HALF_2, BE_HALF_3: begin
        legal = 1'b1;
      end
      BE_WORD_LO, BE_WORD_HI: begin
        is_word = 1'b1;
      end
      default: begin
        legal = 1'b0;
      end
    endcase
  end

  always_comb begin
    cmd.op          = item.op;
    cmd.addr        = item.word_index[ADDR_W-1:0];
    cmd.is_word     = is_word;
    cmd.word_hi     = (item.byte_enable == BE_WORD_HI);
    cmd.byte_enable = item.byte_enable;
    cmd.write_data  = item.write_data;
    if ({1'b0, item.word_index} >= (IDX_W+1)'(MEM_WORDS)) begin
      cmd.err = ERR_RANGE;
    end else if (!legal) begin
      cmd.err = ERR_ENABLE;
    end else begin
      cmd.err = ERR_OK;
    end
  end

endmodule

FILE: hw/rtl/hsb_cmd_queue.sv
// Short queue of decoded commands between front end and back end.
// Depends on hsb_pkg.
module hsb_cmd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  hsb_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output hsb_pkg::cmd_t pop_data,
  output logic          empty
);
  import hsb_pkg::*;

  cmd_t              store_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign full     = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: hw/rtl/hsb_rsp_queue.sv
// Result queue in front of the output port.
// Depends on hsb_pkg.
module hsb_rsp_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  hsb_pkg::out_item_t push_data,
  output logic               full,
  input  logic               pop,
  output hsb_pkg::out_item_t pop_data,
  output logic               empty
);
  import hsb_pkg::*;

  out_item_t         store_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign full     = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: hw/rtl/hsb_back.sv
// Back end: word memory with per-word valid bits and the read-modify-write
// sequencer that pops a command and then pushes its result. Depends on hsb_pkg.
module hsb_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_empty,
  input  hsb_pkg::cmd_t      cmd_data,
  output logic               cmd_pop,
  input  logic               rsp_full,
  output logic               rsp_push,
  output hsb_pkg::out_item_t rsp_data
);
  import hsb_pkg::*;

  logic [DATA_W-1:0]    mem [MEM_WORDS];
  logic [MEM_WORDS-1:0] valid_r;

  back_state_t       state_r, state_nxt;
  cmd_t              cmd_r;
  logic [DATA_W-1:0] rd_word_r;
  logic              rd_valid_r;

  logic [DATA_W-1:0] word;
  logic [DATA_W-1:0] bmask;
  logic [LANE_W-1:0] old_lane, new_lane;
  logic [DATA_W-1:0] new_word;
  logic              wr_en;

  always_comb begin
    state_nxt = state_r;
    cmd_pop   = 1'b0;
    rsp_push  = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!cmd_empty && !rsp_full) begin
          cmd_pop   = 1'b1;
          state_nxt = BK_EXEC;
        end
      end
      BK_EXEC: begin
        rsp_push  = 1'b1;
        state_nxt = BK_IDLE;
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cmd_r      <= cmd_data;
      rd_word_r  <= mem[cmd_data.addr];
      rd_valid_r <= valid_r[cmd_data.addr];
    end
  end

  always_comb begin
    word = rd_valid_r ? rd_word_r : '0;
    for (int k = 0; k < BE_W; k++) begin
      bmask[8*k +: 8] = {8{cmd_r.byte_enable[k]}};
    end
    old_lane = cmd_r.word_hi ? word[DATA_W-1:LANE_W] : word[LANE_W-1:0];
    new_lane = cmd_r.word_hi ? cmd_r.write_data[DATA_W-1:LANE_W]
                             : cmd_r.write_data[LANE_W-1:0];
    rsp_data.read_data  = '0;
    rsp_data.error_code = cmd_r.err;
    wr_en    = 1'b0;
    new_word = word;
    if (cmd_r.err == ERR_OK) begin
      if (!cmd_r.is_word) begin
        if (cmd_r.op == OP_WRITE) begin
          wr_en    = 1'b1;
          new_word = (word & ~bmask) | (cmd_r.write_data & bmask);
        end else begin
          rsp_data.read_data = word & bmask;
        end
      end else if (cmd_r.op == OP_WRITE) begin
        if (new_lane == SEM_TAKEN && old_lane == SEM_LOCKED) begin
          rsp_data.error_code = ERR_DOUBLE_LOCK;
        end else begin
          if (new_lane == SEM_TAKEN && old_lane == SEM_TAKEN) begin
            new_lane = SEM_LOCKED;
          end
          wr_en    = 1'b1;
          new_word = cmd_r.word_hi ? {new_lane, word[LANE_W-1:0]}
                                   : {word[DATA_W-1:LANE_W], new_lane};
        end
      end else begin
        new_lane = (old_lane == SEM_LOCKED) ? SEM_TAKEN : old_lane;
        rsp_data.read_data = cmd_r.word_hi ? {new_lane, {LANE_W{1'b0}}}
                                           : {{LANE_W{1'b0}}, new_lane};
        if (old_lane == SEM_FREE) begin
          wr_en    = 1'b1;
          new_word = cmd_r.word_hi ? {SEM_TAKEN, word[LANE_W-1:0]}
                                   : {word[DATA_W-1:LANE_W], SEM_TAKEN};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_push && wr_en) begin
      mem[cmd_r.addr] <= new_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (rsp_push && wr_en) begin
      valid_r[cmd_r.addr] <= 1'b1;
    end
  end

endmodule

FILE: hw/rtl/hardware_semaphore_bank.sv
// Semaphore bank: bank of 64-bit words with test-and-set on 32-bit reads.
// Usage:
//   Input queue port: drive in_data and raise in_push; the transfer happens
//   on a clock edge with in_push high and in_full low.
//   Result queue port: while out_empty is low, out_data holds the oldest
//   result; raise out_pop to take it.
//   Byte and halfword accesses behave as memory; 32-bit lanes act as
//   semaphores. Errors (address range, illegal enable, double lock) are
//   reported in error_code and leave the words unchanged.
//   Path: an access passes the command queue, the back end's command
//   register and result queue. The back end takes no new access until the
//   last is done: a read-modify-write of the single-port word memory.
//   Reset (rst_n low, synchronous) empties both queues and clears the valid
//   bits, so every word reads as zero; no clearing pass is needed.
//   When the receiver stalls, two results wait in the result queue, then
//   two commands in the command queue, and then in_full rises.
// Depends on hsb_pkg, hsb_front, hsb_cmd_queue, hsb_back, hsb_rsp_queue.
module hardware_semaphore_bank (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  hsb_pkg::in_item_t  in_data,
  output logic               in_full,
  output logic               out_empty,
  input  logic               out_pop,
  output hsb_pkg::out_item_t out_data
);
  import hsb_pkg::*;

  cmd_t      front_cmd;
  cmd_t      q_cmd;
  logic      cmd_empty, cmd_pop;
  logic      rsp_full, rsp_push;
  out_item_t rsp_data;

  hsb_front u_front (
    .item (in_data),
    .cmd  (front_cmd)
  );

  hsb_cmd_queue u_cmd_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_push),
    .push_data (front_cmd),
    .full      (in_full),
    .pop       (cmd_pop),
    .pop_data  (q_cmd),
    .empty     (cmd_empty)
  );

  hsb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_data  (q_cmd),
    .cmd_pop   (cmd_pop),
    .rsp_full  (rsp_full),
    .rsp_push  (rsp_push),
    .rsp_data  (rsp_data)
  );

  hsb_rsp_queue u_rsp_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (rsp_push),
    .push_data (rsp_data),
    .full      (rsp_full),
    .pop       (out_pop),
    .pop_data  (out_data),
    .empty     (out_empty)
  );

  a_push_follows_pop: assert property (@(posedge clk) disable iff (!rst_n)
    rsp_push |-> $past(cmd_pop))
    else $error("result pushed without a command taken the cycle before");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |=> !cmd_pop && rsp_push)
    else $error("back end took a new command before finishing the last");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    rsp_push |-> !rsp_full)
    else $error("result pushed into a full result queue");

  a_error_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    rsp_push && rsp_data.error_code != ERR_OK |-> rsp_data.read_data == '0)
    else $error("error result carries nonzero read data");

endmodule

FILE: test/hsb_access_checker.sv
`timescale 1ns / 1ps
// Result checker for hardware_semaphore_bank: keeps its own copy of the word bank,
// predicts every accepted access and compares each accepted result in order.
// Depends on hsb_pkg.
module hsb_access_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic               in_full,
  input  hsb_pkg::in_item_t  in_data,
  input  logic               out_empty,
  input  logic               out_pop,
  input  hsb_pkg::out_item_t out_data,
  output int                 fail_count,
  output int                 pending,
  output int                 checked_count,
  output int                 error_count,
  output int                 lock_count
);
  import hsb_pkg::*;

  logic [DATA_W-1:0] bank_model [MEM_WORDS];
  out_item_t         awaited_replies [$];

  task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                 logic [DATA_W-1:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
    fail_count++;
  endtask

  function automatic out_item_t apply_access(in_item_t acc);
    out_item_t         reply;
    logic [DATA_W-1:0] word;
    logic [DATA_W-1:0] lane_mask;
    logic [LANE_W-1:0] old_val;
    logic [LANE_W-1:0] new_val;
    int                base;
    logic              legal;
    reply.read_data  = '0;
    reply.error_code = ERR_OK;
    if (acc.word_index >= MEM_WORDS) begin
      reply.error_code = ERR_RANGE;
      return reply;
    end
    legal = $onehot(acc.byte_enable) ||
            (acc.byte_enable inside {BE_HALF_0, BE_HALF_1, BE_HALF_2, BE_HALF_3,
                                     BE_WORD_LO, BE_WORD_HI});
    if (!legal) begin
      reply.error_code = ERR_ENABLE;
      return reply;
    end
    word = bank_model[acc.word_index];
    if (acc.byte_enable == BE_WORD_LO || acc.byte_enable == BE_WORD_HI) begin
      base    = (acc.byte_enable == BE_WORD_HI) ? LANE_W : 0;
      old_val = word[base +: LANE_W];
      if (acc.op == OP_WRITE) begin
        new_val = acc.write_data[base +: LANE_W];
        if (new_val == SEM_TAKEN && old_val == SEM_LOCKED) begin
          reply.error_code = ERR_DOUBLE_LOCK;
        end else begin
          if (new_val == SEM_TAKEN && old_val == SEM_TAKEN) new_val = SEM_LOCKED;
          word[base +: LANE_W] = new_val;
        end
      end else begin
        reply.read_data[base +: LANE_W] = (old_val == SEM_LOCKED) ? SEM_TAKEN : old_val;
        if (old_val == SEM_FREE) word[base +: LANE_W] = SEM_TAKEN;
      end
    end else begin
      for (int b = 0; b < BE_W; b++) lane_mask[8*b +: 8] = {8{acc.byte_enable[b]}};
      if (acc.op == OP_WRITE) word = (word & ~lane_mask) | (acc.write_data & lane_mask);
      else reply.read_data = word & lane_mask;
    end
    bank_model[acc.word_index] = word;
    return reply;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    out_item_t reply;
    if (!rst_n) begin
      foreach (bank_model[i]) bank_model[i] = '0;
      awaited_replies.delete();
      pending <= 0;
    end else begin
      if (out_pop && !out_empty) begin
        if (awaited_replies.size() == 0) begin
          report_mismatch("result with nothing expected", out_data.read_data, '0);
        end else begin
          want = awaited_replies.pop_front();
          checked_count++;
          if (out_data.read_data !== want.read_data)
            report_mismatch("read_data", out_data.read_data, want.read_data);
          if (out_data.error_code !== want.error_code)
            report_mismatch("error_code", DATA_W'(out_data.error_code),
                            DATA_W'(want.error_code));
        end
      end
      if (in_push && !in_full) begin
        reply = apply_access(in_data);
        if (reply.error_code != ERR_OK) error_count++;
        if (reply.error_code == ERR_DOUBLE_LOCK) lock_count++;
        awaited_replies.push_back(reply);
      end
      pending <= awaited_replies.size();
    end
  end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// Top of the semaphore bank test: clock, reset, directed and random accesses with
// random idling on both ports and a long receiver hold-off.
// Depends on hsb_pkg, hardware_semaphore_bank and hsb_access_checker.
module tb;
  import hsb_pkg::*;

  localparam int RANDOM_ACCESSES = 1600;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int STALL_LIMIT     = 2000;
  localparam int DRAIN_CYCLES    = 16;

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      in_push = 1'b0;
  logic      out_pop = 1'b0;
  in_item_t  in_data = '0;
  logic      in_full;
  logic      out_empty;
  out_item_t out_data;

  int fail_count;
  int pending;
  int checked_count;
  int error_count;
  int lock_count;
  int sent_count   = 0;
  int full_cycles  = 0;
  int quiet_cycles = 0;
  bit hold_req     = 1'b0;
  bit gaps_on      = 1'b1;

  hardware_semaphore_bank u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  hsb_access_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_data       (in_data),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked_count (checked_count),
    .error_count   (error_count),
    .lock_count    (lock_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (in_push && in_full) full_cycles <= full_cycles + 1;
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("FAIL hardware_semaphore_bank");
    $finish;
  end

  function automatic logic [BE_W-1:0] pick_legal_enable();
    int k;
    k = $urandom_range(0, 13);
    case (k)
      8:       return BE_HALF_0;
      9:       return BE_HALF_1;
      10:      return BE_HALF_2;
      11:      return BE_HALF_3;
      12:      return BE_WORD_LO;
      13:      return BE_WORD_HI;
      default: return BE_W'(1) << k;
    endcase
  endfunction

  // place a lane value in the selected 32-bit half, noise in the other
  function automatic logic [DATA_W-1:0] lane_data(logic [BE_W-1:0] be,
                                                  logic [LANE_W-1:0] v);
    logic [LANE_W-1:0] noise;
    noise = $urandom;
    return (be == BE_WORD_HI) ? {v, noise} : {noise, v};
  endfunction

  task automatic send_access(op_t kind, logic [IDX_W-1:0] idx, logic [BE_W-1:0] be,
                             logic [DATA_W-1:0] wd);
    in_data <= '{op: kind, word_index: idx, byte_enable: be, write_data: wd};
    in_push <= 1'b1;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sent_count++;
  endtask

  task automatic pause_sender();
    int roll;
    roll = $urandom_range(0, 99);
    if (!gaps_on || roll < 50) return;
    in_push <= 1'b0;
    if (roll < 90) repeat ($urandom_range(1, 3)) @(posedge clk);
    else if (roll < 98) repeat ($urandom_range(4, 12)) @(posedge clk);
    else repeat ($urandom_range(20, 60)) @(posedge clk);
  endtask

  task automatic send_random_access();
    int                roll;
    int                pick;
    op_t               kind;
    logic [IDX_W-1:0]  idx;
    logic [BE_W-1:0]   be;
    logic [DATA_W-1:0] wd;
    logic [LANE_W-1:0] lane_val;
    roll = $urandom_range(0, 99);
    kind = op_t'($urandom_range(0, 1));
    wd   = {$urandom, $urandom};
    idx  = IDX_W'($urandom_range(0, 7));
    be   = pick_legal_enable();
    if (roll < 5) begin
      idx = IDX_W'($urandom_range(MEM_WORDS, 255));
      be  = BE_W'($urandom);
    end else if (roll < 12) begin
      be = BE_W'($urandom);
    end else if (roll < 65) begin
      // semaphore traffic: mostly take, lock and release on a few words
      be   = $urandom_range(0, 1) ? BE_WORD_HI : BE_WORD_LO;
      pick = $urandom_range(0, 9);
      if (pick < 4) lane_val = SEM_TAKEN;
      else if (pick < 7) lane_val = SEM_FREE;
      else if (pick < 8) lane_val = SEM_LOCKED;
      else lane_val = $urandom;
      wd = lane_data(be, lane_val);
    end else if (roll >= 85) begin
      idx = IDX_W'($urandom_range(0, MEM_WORDS - 1));
    end
    send_access(kind, idx, be, wd);
  endtask

  initial begin
    @(posedge clk);
    forever begin
      int roll;
      if (hold_req) begin
        out_pop <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
          out_pop <= 1'b1;
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end else if (roll < 62) begin
          out_pop <= 1'b1;
          repeat ($urandom_range(40, 120)) @(posedge clk);
        end else begin
          out_pop <= 1'b0;
          if (roll < 95) repeat ($urandom_range(1, 3)) @(posedge clk);
          else repeat ($urandom_range(15, 50)) @(posedge clk);
        end
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_access(OP_READ,  0, BE_WORD_LO, '1);
    send_access(OP_READ,  0, BE_WORD_LO, '0);
    send_access(OP_WRITE, 0, BE_WORD_LO, lane_data(BE_WORD_LO, SEM_TAKEN));
    send_access(OP_READ,  0, BE_WORD_LO, '0);
    send_access(OP_WRITE, 0, BE_WORD_LO, lane_data(BE_WORD_LO, SEM_TAKEN));
    send_access(OP_WRITE, 0, BE_WORD_LO, lane_data(BE_WORD_LO, SEM_FREE));
    send_access(OP_WRITE, IDX_W'(MEM_WORDS - 1), BE_WORD_HI, '1);
    send_access(OP_READ,  IDX_W'(MEM_WORDS - 1), BE_WORD_HI, '0);
    send_access(OP_WRITE, IDX_W'(MEM_WORDS - 1), 8'h01, '1);
    send_access(OP_READ,  IDX_W'(MEM_WORDS - 1), 8'h01, '0);
    send_access(OP_WRITE, 5, BE_HALF_3, {$urandom, $urandom});
    send_access(OP_READ,  5, BE_HALF_3, '0);
    send_access(OP_WRITE, 5, 8'h80, '1);
    send_access(OP_READ,  5, BE_HALF_0, '0);
    send_access(OP_READ,  5, BE_HALF_1, '0);
    send_access(OP_READ,  5, BE_HALF_2, '0);
    send_access(OP_READ,  IDX_W'(MEM_WORDS), BE_WORD_LO, '0);
    send_access(OP_WRITE, 8'hFF, 8'h00, '1);
    send_access(OP_READ,  3, 8'h00, '0);
    send_access(OP_WRITE, 3, 8'hFF, '1);
    send_access(OP_READ,  3, 8'h06, '0);
    send_access(OP_WRITE, 7, BE_WORD_HI, lane_data(BE_WORD_HI, SEM_LOCKED));
    send_access(OP_WRITE, 7, BE_WORD_HI, lane_data(BE_WORD_HI, SEM_TAKEN));
    send_access(OP_READ,  7, BE_WORD_HI, '0);
    send_access(OP_WRITE, 7, BE_WORD_LO, lane_data(BE_WORD_LO, SEM_TAKEN));

    for (int i = 0; i < RANDOM_ACCESSES; i++) begin
      if (i == 400 || i == 1100) begin
        hold_req = 1'b1;
        gaps_on  = 1'b0;
      end
      if (i == 440 || i == 1140 || i == 850) gaps_on = 1'b1;
      if (i == 700) gaps_on = 1'b0;
      send_random_access();
      pause_sender();
    end
    in_push <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d accesses sent, %0d results checked, %0d with an error code",
             sent_count, checked_count, error_count);
    $display("%0d double locks; input blocked by a full block for %0d cycles",
             lock_count, full_cycles);
    if (fail_count == 0) $display("PASS hardware_semaphore_bank");
    else $display("FAIL hardware_semaphore_bank");
    $finish;
  end

endmodule
